[sv/wlis_pkg.sv]
// ----------------------------------------------------------------------------
// wlis_pkg
// Shared widths, the tree entry layout and the control bundle that the
// sequencer broadcasts to every level cell of the prefix max tree.
// ----------------------------------------------------------------------------
package wlis_pkg;

   localparam int KEYS_DEFAULT = 4096;

   localparam int KEY_W    = 13;
   localparam int WEIGHT_W = 32;
   localparam int OUT_W    = 44;
   localparam int VAL_W    = 43;
   localparam int EPOCH_W  = 8;

   localparam logic [EPOCH_W-1:0] EPOCH_LAST = '1;

   // one stored maximum, tagged with the clear epoch it was written in
   typedef struct packed {
      logic [EPOCH_W-1:0] tag;
      logic [VAL_W-1:0]   val;
   } entry_type;

   typedef struct packed {
      logic               rd_query;
      logic               rd_update;
      logic               wr_update;
      logic               sweep;
      logic [EPOCH_W-1:0] epoch;
      logic [VAL_W-1:0]   best;
   } cell_ctl_type;

endpackage

[sv/weighted_lis_prefix_max_tree.sv]
// ----------------------------------------------------------------------------
// weighted_lis_prefix_max_tree
// Best weight of a non-decreasing subsequence ending at each request, kept
// in a max prefix tree split into one cell per tree level.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one request (key, signed weight, start flag) with
//   req_valid/req_ready; rsp_* returns one best_total per request with
//   rsp_valid/rsp_ready. csr_* writes reverse_order (always ready); write it
//   only while no request is in flight.
//   One request takes these steps, with LEVELS = clog2(KEYS + 1): two
//   memory reads in every level cell, then the running maximum walks the
//   chain of level cells one per cycle, then the sum step and the update
//   writes. rsp_valid rises when the sum step registers the result.
//   A start flag bumps a clear epoch; every 256th start, and every reset,
//   runs a clearing pass over the tree entries with req_ready low. Reset
//   is synchronous and starts that pass.
//   A result waits in the output register while the next request is
//   accepted; a request only stalls at its sum step if the previous result
//   has still not been taken.
// ----------------------------------------------------------------------------
module weighted_lis_prefix_max_tree #(
   parameter int KEYS = wlis_pkg::KEYS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [wlis_pkg::KEY_W-1:0]            req_key,
   input  logic signed [wlis_pkg::WEIGHT_W-1:0]  req_weight,
   input  logic                                  req_start_req,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [wlis_pkg::OUT_W-1:0]     rsp_best_total,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic                                  csr_reverse_order
);

   localparam int PW     = $clog2(KEYS + 1);
   localparam int LEVELS = PW;
   localparam int MAXD   = (KEYS >> 1) + 1;
   localparam int SW     = $clog2(MAXD);
   localparam int CNW    = $clog2(LEVELS);
   localparam int CMP_W  = (wlis_pkg::KEY_W > PW) ? wlis_pkg::KEY_W : PW;
   localparam int VW     = wlis_pkg::VAL_W;
   localparam int WW     = wlis_pkg::WEIGHT_W;
   localparam int OW     = wlis_pkg::OUT_W;
   localparam int EW     = wlis_pkg::EPOCH_W;
   localparam int SUM_W  = VW + 2;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RDQ,
      ST_RDU,
      ST_CHAIN,
      ST_SUM,
      ST_UPD
   } state_type;

   state_type                    state_ff;
   logic                         reverse_ff;
   logic                         pending_ff;
   logic [wlis_pkg::EPOCH_W-1:0] epoch_ff;
   logic [SW-1:0]                sweep_ff;
   logic [CNW-1:0]               chain_ff;
   logic [PW-1:0]                pos_ff;
   logic [WW-1:0]                weight_ff;
   logic [VW-1:0]                best_val_ff;
   logic                         best_pos_ff;
   logic                         rsp_valid_ff;
   logic [OW-1:0]                rsp_best_ff;

   logic [CMP_W-1:0]             key_ext;
   logic [CMP_W-1:0]             key_clamp;
   logic [CMP_W:0]               pos_wide;
   logic [PW-1:0]                pos_in;
   logic [SUM_W-1:0]             sum_wide;
   logic [OW-1:0]                best_in;
   logic                         best_pos_in;
   logic                         out_free;

   wlis_pkg::cell_ctl_type       cell_ctl;
   logic [VW-1:0]                acc_w [LEVELS+1];

   always_comb begin
      key_ext = CMP_W'(req_key);
      if (key_ext == '0) begin
         key_clamp = CMP_W'(1);
      end else if (key_ext > CMP_W'(KEYS)) begin
         key_clamp = CMP_W'(KEYS);
      end else begin
         key_clamp = key_ext;
      end
      // reverse pass mirrors the key onto the tree positions
      pos_wide = reverse_ff ? ((CMP_W+1)'(KEYS) + (CMP_W+1)'(1) - {1'b0, key_clamp})
                            : {1'b0, key_clamp};
      pos_in   = PW'(pos_wide);

      sum_wide = {2'b00, acc_w[LEVELS]} + {{(SUM_W-WW){weight_ff[WW-1]}}, weight_ff};
      if (!sum_wide[SUM_W-1] && (sum_wide[SUM_W-2:VW] != '0)) begin
         best_in = {1'b0, {VW{1'b1}}};
      end else begin
         best_in = sum_wide[OW-1:0];
      end
      best_pos_in = !best_in[OW-1] && (best_in != '0);
      out_free    = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      cell_ctl.rd_query  = (state_ff == ST_RDQ);
      cell_ctl.rd_update = (state_ff == ST_RDU);
      cell_ctl.wr_update = (state_ff == ST_UPD) && best_pos_ff;
      cell_ctl.sweep     = (state_ff == ST_CLEAR);
      cell_ctl.epoch     = epoch_ff;
      cell_ctl.best      = best_val_ff;
   end

   assign acc_w[0] = '0;

   for (genvar g = 0; g < LEVELS; g++) begin : g_level
      wlis_cell #(
         .LEVEL   (g),
         .KEYS    (KEYS),
         .SWEEP_W (SW)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (cell_ctl),
         .pos        (pos_ff),
         .sweep_addr (sweep_ff),
         .acc_left   (acc_w[g]),
         .acc_out    (acc_w[g+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         reverse_ff   <= 1'b0;
         pending_ff   <= 1'b0;
         epoch_ff     <= '0;
         sweep_ff     <= '0;
         chain_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            reverse_ff <= csr_reverse_order;
         end
         if ((state_ff == ST_SUM) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_CLEAR: begin
               if (sweep_ff == SW'(MAXD - 1)) begin
                  sweep_ff   <= '0;
                  pending_ff <= 1'b0;
                  state_ff   <= pending_ff ? ST_RDQ : ST_IDLE;
               end else begin
                  sweep_ff <= sweep_ff + SW'(1);
               end
            end
            ST_IDLE: begin
               if (req_valid) begin
                  pos_ff    <= pos_in;
                  weight_ff <= req_weight;
                  if (req_start_req && (epoch_ff == wlis_pkg::EPOCH_LAST)) begin
                     // epoch space used up: wipe the tree and restart at zero
                     epoch_ff   <= '0;
                     pending_ff <= 1'b1;
                     state_ff   <= ST_CLEAR;
                  end else begin
                     state_ff <= ST_RDQ;
                     if (req_start_req) begin
                        epoch_ff <= epoch_ff + EW'(1);
                     end
                  end
               end
            end
            ST_RDQ: begin
               state_ff <= ST_RDU;
            end
            ST_RDU: begin
               chain_ff <= '0;
               state_ff <= ST_CHAIN;
            end
            ST_CHAIN: begin
               chain_ff <= chain_ff + CNW'(1);
               if (chain_ff == CNW'(LEVELS - 1)) begin
                  state_ff <= ST_SUM;
               end
            end
            ST_SUM: begin
               if (out_free) begin
                  rsp_best_ff  <= best_in;
                  best_val_ff  <= best_in[VW-1:0];
                  best_pos_ff  <= best_pos_in;
                  state_ff     <= ST_UPD;
               end
            end
            ST_UPD: begin
               state_ff <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_ready      = (state_ff == ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_best_total = rsp_best_ff;
   assign csr_ready      = 1'b1;

endmodule

[sv/wlis_cell.sv]
// ----------------------------------------------------------------------------
// wlis_cell
// One level of the max prefix tree: holds every tree entry whose lowest set
// position bit is LEVEL, folds its query entry into the running maximum
// handed from the lower level, and applies the update write for its level.
// ----------------------------------------------------------------------------
module wlis_cell #(
   parameter int LEVEL   = 0,
   parameter int KEYS    = wlis_pkg::KEYS_DEFAULT,
   parameter int SWEEP_W = 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  wlis_pkg::cell_ctl_type      ctl,
   input  logic [$clog2(KEYS+1)-1:0]   pos,
   input  logic [SWEEP_W-1:0]          sweep_addr,
   input  logic [wlis_pkg::VAL_W-1:0]  acc_left,
   output logic [wlis_pkg::VAL_W-1:0]  acc_out
);

   localparam int PW    = $clog2(KEYS + 1);
   localparam int DEPTH = (KEYS >> (LEVEL + 1)) + 1;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   wlis_pkg::entry_type mem [DEPTH];
   wlis_pkg::entry_type rd_ff;

   logic                       qcap_ff;
   logic                       ucap_ff;
   logic [wlis_pkg::VAL_W-1:0] qval_ff;
   logic [wlis_pkg::VAL_W-1:0] uval_ff;
   logic [wlis_pkg::VAL_W-1:0] acc_ff;
   logic [wlis_pkg::VAL_W-1:0] acc_in;

   logic [PW-1:0]              pm1;
   logic [PW:0]                upos;
   logic                       q_en;
   logic                       u_en;
   logic [AW-1:0]              qidx;
   logic [AW-1:0]              uidx;
   logic [AW-1:0]              raddr;
   logic [AW-1:0]              sidx;
   logic                       sweep_hit;
   logic [wlis_pkg::VAL_W-1:0] ent_val;
   logic [wlis_pkg::VAL_W-1:0] upd_val;

   always_comb begin
      pm1   = pos - PW'(1);
      // query touches this level when the position has bit LEVEL set
      q_en  = pos[LEVEL];
      qidx  = AW'(pos >> (LEVEL + 1));
      // update touches the entry of this level whose range covers the position
      uidx  = AW'(pm1 >> (LEVEL + 1));
      upos  = ((PW+1)'(pm1 >> LEVEL) + (PW+1)'(1)) << LEVEL;
      u_en  = !pm1[LEVEL] && (upos <= (PW+1)'(KEYS));
      raddr = ctl.rd_update ? uidx : qidx;
      // entries from an older epoch read as cleared
      ent_val = (rd_ff.tag == ctl.epoch) ? rd_ff.val : '0;
      upd_val = (uval_ff > ctl.best) ? uval_ff : ctl.best;
      sidx      = AW'(sweep_addr);
      sweep_hit = {1'b0, sweep_addr} < (SWEEP_W+1)'(DEPTH);
      acc_in    = (acc_left > qval_ff) ? acc_left : qval_ff;
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_query || ctl.rd_update) begin
         rd_ff <= mem[raddr];
      end
      if (ctl.sweep) begin
         if (sweep_hit) begin
            mem[sidx] <= '0;
         end
      end else if (ctl.wr_update && u_en) begin
         mem[uidx] <= '{tag: ctl.epoch, val: upd_val};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         qcap_ff <= 1'b0;
         ucap_ff <= 1'b0;
      end else begin
         qcap_ff <= ctl.rd_query;
         ucap_ff <= ctl.rd_update;
      end
   end

   always_ff @(posedge clock) begin
      if (qcap_ff) begin
         qval_ff <= q_en ? ent_val : '0;
      end
      if (ucap_ff) begin
         uval_ff <= ent_val;
      end
      acc_ff <= acc_in;
   end

   assign acc_out = acc_ff;

endmodule

[sv/wlis_checker.sv]
// ----------------------------------------------------------------------------
// wlis_checker
// Port-level checks on the request and response channels of the prefix
// max tree block, bound to every instance of the top level.
// ----------------------------------------------------------------------------
module wlis_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_ready,
   input logic [wlis_pkg::KEY_W-1:0]            req_key,
   input logic signed [wlis_pkg::WEIGHT_W-1:0]  req_weight,
   input logic                                  req_start_req,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic signed [wlis_pkg::OUT_W-1:0]     rsp_best_total,
   input logic                                  csr_valid,
   input logic                                  csr_ready,
   input logic                                  csr_reverse_order
);

   // a pending response is held until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before it was taken");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_best_total))
      else $error("stalled response changed");

   // reset starts the clearing pass
   a_reset_busy: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request channel ready right after reset");

   // one request in flight at a time
   a_one_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while previous one in flight");

   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !req_ready)
      else $error("response produced while block was idle");

endmodule

bind weighted_lis_prefix_max_tree wlis_checker u_wlis_checker (.*);
